// ===== sv/kmst_pkg.sv =====
// Shared constants and controller/datapath interface types for the spanning tree builder.
`default_nettype none

package kmst_pkg;

   localparam int MAX_VERTICES = 4096;
   localparam int VID_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = VID_W + 1;
   localparam int WEIGHT_W     = 20;
   localparam int TOTAL_W      = 32;
   localparam int CFG_W        = 13;

   localparam logic [CNT_W-1:0]   MAX_COUNT    = CNT_W'(MAX_VERTICES);
   localparam logic [CFG_W-1:0]   CFG_RESET    = CFG_W'(4096);
   localparam logic [VID_W-1:0]   LAST_VERTEX  = VID_W'(MAX_VERTICES - 1);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

   // Item codes carried by the func field
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_EDGE  = 1'b1;

   typedef struct packed {
      logic accept;
      logic start;
      logic clear_write;
      logic check;
      logic lbl_addr_b;
      logic cap_la;
      logic cap_lb;
      logic size_addr_b;
      logic cap_size_a;
      logic cap_size_b;
      logic decide;
      logic walk_step;
      logic walk_next;
      logic tail_addr_gone;
      logic cap_tail_keep;
      logic cap_tail_gone;
      logic append;
      logic load_rsp;
   } kmst_cmd_type;

   typedef struct packed {
      logic bad;
      logic complete;
      logic same_label;
      logic steps_zero;
      logic clear_last;
   } kmst_status_type;

endpackage

`default_nettype wire

// ===== sv/kruskal_mst_union_find_top.sv =====
// Top level of the Kruskal spanning tree builder over a member-list union-find store.
// Sequence: a start item clears every store row, one store row cleared per cycle; an edge
// is rejected on a bad vertex, a complete tree or equal labels, else it is taken and merged.
// Throughput: one item at a time; the relabel walk over the smaller component, a label write
// and a next-member read per member through the next-member memory port, sets the cost of a union.
// Reset: synchronous, active high; clears control, totals and the vertex count register to 4096.
`default_nettype none

module kruskal_mst_union_find_top
   import kmst_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // Input items
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_func,
   input  wire logic [VID_W-1:0]    req_first_vertex,
   input  wire logic [VID_W-1:0]    req_second_vertex,
   input  wire logic [WEIGHT_W-1:0] req_edge_weight,
   // Result items
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_edge_taken,
   output logic [TOTAL_W-1:0]       rsp_tree_weight,
   output logic [VID_W-1:0]         rsp_edges_taken,
   output logic                     rsp_tree_complete,
   output logic                     rsp_bad_vertex,
   // Vertex count register
   input  wire logic                csr_write_enable,
   input  wire logic [CFG_W-1:0]    csr_write_data
);

   // The controller owns both handshakes and steps the datapath one command
   // set per cycle. A start item sweeps all four stores row by row; an edge
   // item that passes the vertex check reads both labels, compares, and if they
   // differ reads both sizes, then relabels the smaller component by walking its
   // member list and appends it to the larger list. The result register lets a
   // new item in while the previous result still waits on rsp_stall.
   kmst_cmd_type    cmd;
   kmst_status_type status;

   kmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kmst_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_first_vertex  (req_first_vertex),
      .req_second_vertex (req_second_vertex),
      .req_edge_weight   (req_edge_weight),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_edge_taken    (rsp_edge_taken),
      .rsp_tree_weight   (rsp_tree_weight),
      .rsp_edges_taken   (rsp_edges_taken),
      .rsp_tree_complete (rsp_tree_complete),
      .rsp_bad_vertex    (rsp_bad_vertex)
   );

   // A rejected endpoint never yields a taken edge
   a_bad_not_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_vertex) |-> !rsp_edge_taken)
      else $error("bad vertex item reported as taken");

   // A taken edge leaves a nonzero edge count
   a_taken_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_edge_taken) |-> (rsp_edges_taken != '0))
      else $error("taken edge with zero edge count");

   // Accepting an item makes the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block still open right after accepting an item");

   // Control reaches the datapath one step at a time
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_write, cmd.walk_step, cmd.walk_next, cmd.append, cmd.load_rsp}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== sv/kmst_ctrl.sv =====
// Sequencer for the spanning tree builder: handshakes, clear sweep, lookup, relabel walk.
`default_nettype none

module kmst_ctrl
   import kmst_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic            req_func,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire kmst_status_type status,
   output kmst_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CHECK,
      ST_RD_LB,
      ST_RD_WAIT,
      ST_CMP,
      ST_SZ_B,
      ST_SZ_WAIT,
      ST_DECIDE,
      ST_WALK_TEST,
      ST_WALK_RD,
      ST_WALK_NX,
      ST_TAIL_A,
      ST_TAIL_B,
      ST_TAIL_C,
      ST_APPEND,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cmd.accept   = accept;
      cmd.start    = accept && (req_func == FUNC_START);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_func == FUNC_START) ? ST_CLEAR : ST_CHECK;
            end
         end
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = (status.bad || status.complete) ? ST_FINISH : ST_RD_LB;
         end
         ST_RD_LB: begin
            cmd.lbl_addr_b = 1'b1;
            cmd.cap_la     = 1'b1;
            state_in       = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            cmd.cap_lb = 1'b1;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            state_in = status.same_label ? ST_FINISH : ST_SZ_B;
         end
         ST_SZ_B: begin
            cmd.size_addr_b = 1'b1;
            cmd.cap_size_a  = 1'b1;
            state_in        = ST_SZ_WAIT;
         end
         ST_SZ_WAIT: begin
            cmd.cap_size_b = 1'b1;
            state_in       = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_WALK_TEST;
         end
         ST_WALK_TEST: begin
            state_in = status.steps_zero ? ST_TAIL_A : ST_WALK_RD;
         end
         ST_WALK_RD: begin
            cmd.walk_step = 1'b1;
            state_in      = ST_WALK_NX;
         end
         ST_WALK_NX: begin
            cmd.walk_next = 1'b1;
            state_in      = status.steps_zero ? ST_TAIL_A : ST_WALK_RD;
         end
         ST_TAIL_A: begin
            state_in = ST_TAIL_B;
         end
         ST_TAIL_B: begin
            cmd.tail_addr_gone = 1'b1;
            cmd.cap_tail_keep  = 1'b1;
            state_in           = ST_TAIL_C;
         end
         ST_TAIL_C: begin
            cmd.cap_tail_gone = 1'b1;
            state_in          = ST_APPEND;
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/kmst_datapath.sv =====
// Datapath: union-find memories, totals, vertex count register and result registers.
`default_nettype none

module kmst_datapath
   import kmst_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire kmst_cmd_type        cmd,
   output kmst_status_type          status,
   input  wire logic [VID_W-1:0]    req_first_vertex,
   input  wire logic [VID_W-1:0]    req_second_vertex,
   input  wire logic [WEIGHT_W-1:0] req_edge_weight,
   input  wire logic                csr_write_enable,
   input  wire logic [CFG_W-1:0]    csr_write_data,
   output logic                     rsp_edge_taken,
   output logic [TOTAL_W-1:0]       rsp_tree_weight,
   output logic [VID_W-1:0]         rsp_edges_taken,
   output logic                     rsp_tree_complete,
   output logic                     rsp_bad_vertex
);

   logic [VID_W-1:0] label_mem [MAX_VERTICES];
   logic [VID_W-1:0] next_mem  [MAX_VERTICES];
   logic [VID_W-1:0] tail_mem  [MAX_VERTICES];
   logic [CNT_W-1:0] size_mem  [MAX_VERTICES];

   logic [CFG_W-1:0]    vc_ff;
   logic [TOTAL_W-1:0]  weight_ff, weight_in;
   logic [VID_W-1:0]    count_ff;
   logic [VID_W-1:0]    clr_idx_ff;
   logic [VID_W-1:0]    a_ff, b_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic                bad_ff, taken_ff;
   logic [VID_W-1:0]    la_ff, lb_ff, keep_ff, gone_ff, walk_ff;
   logic [CNT_W-1:0]    size_a_ff, size_b_ff, steps_ff;
   logic [VID_W-1:0]    tail_keep_ff, tail_gone_ff;
   logic [VID_W-1:0]    label_rd_ff, next_rd_ff, tail_rd_ff;
   logic [CNT_W-1:0]    size_rd_ff;
   logic                rsp_taken_ff, rsp_complete_ff, rsp_bad_ff;
   logic [TOTAL_W-1:0]  rsp_weight_ff;
   logic [VID_W-1:0]    rsp_count_ff;

   logic [CNT_W-1:0]    live_n;
   logic [CNT_W-1:0]    live_n_m1;
   logic                complete;
   logic                keep_first;
   logic [CNT_W-1:0]    size_gone;
   logic [TOTAL_W:0]    weight_sum;
   logic [VID_W-1:0]    label_rd_addr, tail_rd_addr;
   logic [VID_W-1:0]    size_rd_addr;

   // Effective vertex count clamps to the store depth
   assign live_n    = (vc_ff > MAX_COUNT) ? MAX_COUNT : vc_ff;
   assign live_n_m1 = live_n - CNT_W'(1);
   assign complete  = (live_n != '0) && ({1'b0, count_ff} >= live_n_m1);

   assign keep_first = !(size_a_ff < size_b_ff);
   assign size_gone  = keep_first ? size_b_ff : size_a_ff;
   assign weight_sum = {1'b0, weight_ff} + (TOTAL_W + 1)'(w_ff);
   assign weight_in  = weight_sum[TOTAL_W] ? TOTAL_MAX : weight_sum[TOTAL_W-1:0];

   assign label_rd_addr = cmd.lbl_addr_b ? b_ff : a_ff;
   assign size_rd_addr  = cmd.size_addr_b ? lb_ff : la_ff;
   assign tail_rd_addr  = cmd.tail_addr_gone ? gone_ff : keep_ff;

   assign status.bad        = ({1'b0, a_ff} >= live_n) || ({1'b0, b_ff} >= live_n);
   assign status.complete   = complete;
   assign status.same_label = (la_ff == lb_ff);
   assign status.steps_zero = (steps_ff == '0);
   assign status.clear_last = (clr_idx_ff == LAST_VERTEX);

   // Memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (cmd.clear_write) begin
         label_mem[clr_idx_ff] <= clr_idx_ff;
      end else if (cmd.walk_step) begin
         label_mem[walk_ff] <= keep_ff;
      end
      label_rd_ff <= label_mem[label_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_write) begin
         next_mem[clr_idx_ff] <= clr_idx_ff;
      end else if (cmd.append) begin
         next_mem[tail_keep_ff] <= gone_ff;
      end
      next_rd_ff <= next_mem[walk_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_write) begin
         tail_mem[clr_idx_ff] <= clr_idx_ff;
      end else if (cmd.append) begin
         tail_mem[keep_ff] <= tail_gone_ff;
      end
      tail_rd_ff <= tail_mem[tail_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_write) begin
         size_mem[clr_idx_ff] <= CNT_W'(1);
      end else if (cmd.append) begin
         size_mem[keep_ff] <= size_a_ff + size_b_ff;
      end
      size_rd_ff <= size_mem[size_rd_addr];
   end

   // Configuration and running totals
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff     <= CFG_RESET;
         weight_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            vc_ff <= csr_write_data;
         end
         if (cmd.start) begin
            weight_ff <= '0;
            count_ff  <= '0;
         end else if (cmd.decide) begin
            weight_ff <= weight_in;
            count_ff  <= count_ff + VID_W'(1);
         end
      end
   end

   // Working registers of one item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         a_ff     <= req_first_vertex;
         b_ff     <= req_second_vertex;
         w_ff     <= req_edge_weight;
         bad_ff   <= 1'b0;
         taken_ff <= 1'b0;
      end
      if (cmd.start) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_idx_ff <= clr_idx_ff + VID_W'(1);
      end
      if (cmd.check) begin
         bad_ff <= status.bad;
      end
      if (cmd.cap_la) begin
         la_ff <= label_rd_ff;
      end
      if (cmd.cap_lb) begin
         lb_ff <= label_rd_ff;
      end
      if (cmd.cap_size_a) begin
         size_a_ff <= size_rd_ff;
      end
      if (cmd.cap_size_b) begin
         size_b_ff <= size_rd_ff;
      end
      if (cmd.decide) begin
         taken_ff <= 1'b1;
         keep_ff  <= keep_first ? la_ff : lb_ff;
         gone_ff  <= keep_first ? lb_ff : la_ff;
         walk_ff  <= keep_first ? lb_ff : la_ff;
         steps_ff <= (size_gone > MAX_COUNT) ? MAX_COUNT : size_gone;
      end else if (cmd.walk_step) begin
         steps_ff <= steps_ff - CNT_W'(1);
      end else if (cmd.walk_next) begin
         walk_ff <= next_rd_ff;
      end
      if (cmd.cap_tail_keep) begin
         tail_keep_ff <= tail_rd_ff;
      end
      if (cmd.cap_tail_gone) begin
         tail_gone_ff <= tail_rd_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_taken_ff    <= taken_ff;
         rsp_weight_ff   <= weight_ff;
         rsp_count_ff    <= count_ff;
         rsp_complete_ff <= complete;
         rsp_bad_ff      <= bad_ff;
      end
   end

   assign rsp_edge_taken    = rsp_taken_ff;
   assign rsp_tree_weight   = rsp_weight_ff;
   assign rsp_edges_taken   = rsp_count_ff;
   assign rsp_tree_complete = rsp_complete_ff;
   assign rsp_bad_vertex    = rsp_bad_ff;

endmodule

`default_nettype wire
